### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands, clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### hdl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// Types and constants shared by the chunk pool free-list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 32;
    localparam int CHUNK_W = 21;
    localparam int ALIGN_W = 4;
    localparam int FC_W    = 11;
    localparam int CFG_IDX_W = 2;

    // largest usable alignment exponent
    localparam logic [ALIGN_W-1:0] ALIGN_MAX_LG = 4'd12;

    // item operations
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BOUNDS = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADCFG = 3'd4
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_BUFLEN = 2'd1,
        CFG_CHUNK  = 2'd2,
        CFG_ALIGN  = 2'd3
    } t_cfg_idx;

    // rebuild unit to controller
    typedef struct packed {
        logic wr_en;
        logic done;
        logic bad;
    } t_rb_ctrl;

endpackage

`default_nettype wire

### hdl/fcp_stack_mem.sv
// ----------------------------------------------------------------------------
// fcp_stack_mem
// Free-list storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_stack_mem import fcp_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IDX_W-1:0]  i_widx,
    input  wire logic [ADDR_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [IDX_W-1:0]  i_ridx,
    output logic      [ADDR_W-1:0] o_rdata
);

    logic [ADDR_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_widx] <= i_wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_ridx];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/fcp_rebuild.sv
// ----------------------------------------------------------------------------
// fcp_rebuild
// Pool rebuild sequencer: aligns, checks and trims the region, then, if the
// layout is good, pushes one chunk address per cycle into the free list.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_rebuild import fcp_pkg::*; #(
    parameter int MAX_CHUNKS = 1024,
    parameter int CNT_W      = 11,
    parameter int IDX_W      = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [ADDR_W-1:0]  i_base,
    input  wire logic [LEN_W-1:0]   i_buf_len,
    input  wire logic [CHUNK_W-1:0] i_chunk_bytes,
    input  wire logic [ALIGN_W-1:0] i_align_lg,
    output t_rb_ctrl                o_ctrl,
    output logic      [IDX_W-1:0]   o_wr_idx,
    output logic      [ADDR_W-1:0]  o_wr_data,
    output logic      [CNT_W-1:0]   o_count,
    output logic      [ADDR_W-1:0]  o_region_start,
    output logic      [LEN_W-1:0]   o_region_len
);

    typedef enum logic [2:0] {
        RB_IDLE,
        RB_ALIGN,
        RB_CHECK,
        RB_TRIM,
        RB_FILL
    } t_rb_state;

    t_rb_state           r_state;
    logic                r_done;
    logic                r_bad;
    logic                r_bad_chk;
    logic [ADDR_W:0]     r_start;     // aligned base, carry in top bit
    logic [CHUNK_W:0]    r_chunk;     // aligned chunk size
    logic [12:0]         r_pad;
    logic [ADDR_W:0]     r_lim;       // room left below 2^32
    logic [ADDR_W:0]     r_off;
    logic [ADDR_W:0]     r_end;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]   r_region_start;
    logic [LEN_W-1:0]    r_region_len;

    logic [ALIGN_W-1:0]  w_lg;
    logic [12:0]         w_mask;
    logic [ADDR_W:0]     w_start;
    logic [CHUNK_W:0]    w_chunk;
    logic [ADDR_W:0]     w_pad;
    logic [LEN_W-1:0]    w_len0;
    logic [LEN_W-1:0]    w_len;
    logic                w_short;
    logic                w_push;

    // alignment of base and chunk size
    always_comb begin
        w_lg    = (i_align_lg > ALIGN_MAX_LG) ? ALIGN_MAX_LG : i_align_lg;
        w_mask  = (13'd1 << w_lg) - 13'd1;
        w_start = ({1'b0, i_base} + {20'd0, w_mask}) & ~{20'd0, w_mask};
        w_chunk = ({1'b0, i_chunk_bytes} + {9'd0, w_mask}) & ~{9'd0, w_mask};
    end

    // padding and trimmed length
    always_comb begin
        w_pad   = r_start - {1'b0, i_base};
        w_len0  = i_buf_len - {19'd0, r_pad};
        w_len   = ({1'b0, w_len0} > r_lim) ? r_lim[LEN_W-1:0] : w_len0;
        w_short = (w_len <= {10'd0, r_chunk});
    end

    // next chunk fits and the list has room
    assign w_push = (r_end <= {1'b0, r_region_len}) && (r_cnt < CNT_W'(MAX_CHUNKS));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= RB_IDLE;
            r_done         <= 1'b0;
            r_bad          <= 1'b0;
            r_cnt          <= '0;
            r_region_start <= '0;
            r_region_len   <= '0;
            r_chunk        <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                RB_IDLE: begin
                    if (i_start) begin
                        r_state <= RB_ALIGN;
                    end
                end
                RB_ALIGN: begin
                    r_start <= w_start;
                    r_chunk <= w_chunk;
                    r_cnt   <= '0;
                    r_state <= RB_CHECK;
                end
                RB_CHECK: begin
                    r_pad     <= w_pad[12:0];
                    r_lim     <= {1'b1, {ADDR_W{1'b0}}} - r_start;
                    r_bad_chk <= r_start[ADDR_W] || ({19'd0, w_pad[12:0]} > i_buf_len)
                                 || (r_chunk == '0);
                    r_state   <= RB_TRIM;
                end
                RB_TRIM: begin
                    r_region_start <= r_start[ADDR_W-1:0];
                    r_off          <= '0;
                    r_end          <= {11'd0, r_chunk};
                    if (r_bad_chk || w_short) begin
                        r_region_len <= '0;
                        r_bad        <= 1'b1;
                        r_done       <= 1'b1;
                        r_state      <= RB_IDLE;
                    end else begin
                        r_region_len <= w_len;
                        r_bad        <= 1'b0;
                        r_state      <= RB_FILL;
                    end
                end
                RB_FILL: begin
                    if (w_push) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_off <= r_off + {11'd0, r_chunk};
                        r_end <= r_end + {11'd0, r_chunk};
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= RB_IDLE;
                    end
                end
                default: begin
                    r_state <= RB_IDLE;
                end
            endcase
        end
    end

    assign o_ctrl.wr_en   = (r_state == RB_FILL) && w_push;
    assign o_ctrl.done    = r_done;
    assign o_ctrl.bad     = r_bad;
    assign o_wr_idx       = r_cnt[IDX_W-1:0];
    assign o_wr_data      = r_region_start + r_off[ADDR_W-1:0];
    assign o_count        = r_cnt;
    assign o_region_start = r_region_start;
    assign o_region_len   = r_region_len;

endmodule

`default_nettype wire

### hdl/fixed_chunk_pool_free_list.sv
// ----------------------------------------------------------------------------
// fixed_chunk_pool_free_list
// Fixed-size chunk pool kept as a LIFO stack of chunk addresses in memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                                   handshake
//  input     in         i_op, i_addr                              i_valid/o_ready
//  result    out        o_chunk_addr, o_status, o_free_count      o_valid/i_ready
//  config    in         i_cfg_idx, i_cfg_data                     i_cfg_we
//
//  Alloc reads the top entry at the accept edge and S_POP registers it as the result.
//  Free, undefined ops and alloc on an empty list register the result at the accept edge.
//  Rebuild aligns, checks and trims the layout, then fills with one push per cycle; a bad layout fills nothing.
//  A new beat is taken only in idle, while the result register is empty or draining.
//  Reset empties the list; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_chunk_pool_free_list import fcp_pkg::*; #(
    parameter int MAX_CHUNKS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_op,
    input  wire logic [ADDR_W-1:0]    i_addr,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [ADDR_W-1:0]    o_chunk_addr,
    output logic      [2:0]           o_status,
    output logic      [FC_W-1:0]      o_free_count,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ADDR_W-1:0]    i_cfg_data
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_REBUILD
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_valid;
    logic [ADDR_W-1:0]   r_chunk_addr;
    t_status             r_status;

    logic [ADDR_W-1:0]   r_base;
    logic [LEN_W-1:0]    r_buf_len;
    logic [CHUNK_W-1:0]  r_chunk_bytes;
    logic [ALIGN_W-1:0]  r_align_lg;

    t_rb_ctrl            rb_ctrl;
    logic [IDX_W-1:0]    rb_wr_idx;
    logic [ADDR_W-1:0]   rb_wr_data;
    logic [CNT_W-1:0]    rb_count;
    logic [ADDR_W-1:0]   rb_region_start;
    logic [LEN_W-1:0]    rb_region_len;

    logic                w_acc;
    logic [CNT_W-1:0]    w_cnt_dec;
    logic [ADDR_W:0]     w_diff;
    logic                w_in_bounds;
    logic                w_full;
    logic                w_free_push;
    logic                w_pop_rd;
    logic                w_mem_we;
    logic [IDX_W-1:0]    w_mem_widx;
    logic [ADDR_W-1:0]   w_mem_wdata;
    logic [ADDR_W-1:0]   w_mem_rdata;
    logic [CNT_W+FC_W-1:0] w_fc_ext;

    // input handshake
    assign o_ready = (r_state == S_IDLE) && (!r_valid || i_ready);
    assign w_acc   = i_valid && o_ready;

    // free checks: region bounds and stack room
    assign w_diff      = {1'b0, i_addr} - {1'b0, rb_region_start};
    assign w_in_bounds = !w_diff[ADDR_W] && (w_diff[ADDR_W-1:0] < rb_region_len);
    assign w_full      = (r_count == CNT_W'(MAX_CHUNKS));
    assign w_free_push = w_acc && (i_op == OP_FREE) && (i_addr != '0)
                         && w_in_bounds && !w_full;

    // pop reads the top entry at the accept edge
    assign w_cnt_dec = r_count - CNT_W'(1);
    assign w_pop_rd  = w_acc && (i_op == OP_ALLOC) && (r_count != '0);

    // stack write: rebuild fill or free push, never both
    assign w_mem_we    = rb_ctrl.wr_en || w_free_push;
    assign w_mem_widx  = rb_ctrl.wr_en ? rb_wr_idx  : r_count[IDX_W-1:0];
    assign w_mem_wdata = rb_ctrl.wr_en ? rb_wr_data : i_addr;

    fcp_stack_mem #(
        .DEPTH (MAX_CHUNKS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_widx  (w_mem_widx),
        .i_wdata (w_mem_wdata),
        .i_re    (w_pop_rd),
        .i_ridx  (w_cnt_dec[IDX_W-1:0]),
        .o_rdata (w_mem_rdata)
    );

    fcp_rebuild #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_rebuild (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_acc && (i_op == OP_REBUILD)),
        .i_base         (r_base),
        .i_buf_len      (r_buf_len),
        .i_chunk_bytes  (r_chunk_bytes),
        .i_align_lg     (r_align_lg),
        .o_ctrl         (rb_ctrl),
        .o_wr_idx       (rb_wr_idx),
        .o_wr_data      (rb_wr_data),
        .o_count        (rb_count),
        .o_region_start (rb_region_start),
        .o_region_len   (rb_region_len)
    );

    // controller, config registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_valid       <= 1'b0;
            r_base        <= '0;
            r_buf_len     <= '0;
            r_chunk_bytes <= CHUNK_W'(64);
            r_align_lg    <= ALIGN_W'(4);
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE:   r_base        <= i_cfg_data;
                    CFG_BUFLEN: r_buf_len     <= i_cfg_data;
                    CFG_CHUNK:  r_chunk_bytes <= i_cfg_data[CHUNK_W-1:0];
                    CFG_ALIGN:  r_align_lg    <= i_cfg_data[ALIGN_W-1:0];
                    default:    r_base        <= r_base;
                endcase
            end

            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_chunk_addr <= '0;
                        case (t_op'(i_op))
                            OP_ALLOC: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_valid  <= 1'b1;
                                end else begin
                                    r_count <= w_cnt_dec;
                                    r_state <= S_POP;
                                end
                            end
                            OP_FREE: begin
                                r_valid <= 1'b1;
                                if (i_addr == '0) begin
                                    r_status <= ST_OK;
                                end else if (!w_in_bounds) begin
                                    r_status <= ST_BOUNDS;
                                end else if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_count  <= r_count + CNT_W'(1);
                                end
                            end
                            OP_REBUILD: begin
                                r_state <= S_REBUILD;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_valid  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_chunk_addr <= w_mem_rdata;
                    r_status     <= ST_OK;
                    r_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_REBUILD: begin
                    if (rb_ctrl.done) begin
                        r_count      <= rb_count;
                        r_chunk_addr <= '0;
                        r_status     <= rb_ctrl.bad ? ST_BADCFG : ST_OK;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // count moves only when the result register is empty or draining, so it is the beat's count
    assign w_fc_ext     = {{FC_W{1'b0}}, r_count};
    assign o_free_count = w_fc_ext[FC_W-1:0];
    assign o_valid      = r_valid;
    assign o_chunk_addr = r_chunk_addr;
    assign o_status     = r_status;

    // checks
    `ASSERT_IMP(a_count_cap, 1'b1, r_count <= CNT_W'(MAX_CHUNKS))
    `ASSERT_IMP(a_fill_in_rebuild, rb_ctrl.wr_en, r_state == S_REBUILD)
    `ASSERT_IMP(a_one_writer, rb_ctrl.wr_en, !w_free_push)
    `ASSERT_NEXT(a_pop_path, w_pop_rd, (r_state == S_POP) && !r_valid)

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunk pool free list. A directed table covers
// reset behavior, every operation and the bad-layout and boundary cases; then
// random pool layouts are each exercised by mixed item traffic that partly
// hands back chunks the bench knows it holds. Every result beat is compared
// field by field against the table or a local model of the pool, under random
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

module tb_top import fcp_pkg::*; ();

    localparam int          POOL_DEPTH   = 1024;
    localparam int          RANDOM_ITEMS = 1900;
    localparam logic [63:0] ADDR_TOP     = 64'h1_0000_0000;

    typedef struct packed {
        logic [ADDR_W-1:0] chunk_addr;
        t_status           status;
        logic [FC_W-1:0]   free_count;
    } pool_result_t;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        logic              is_cfg;
        t_cfg_idx          reg_idx;
        t_op               op;
        logic [31:0]       value;
        logic              typed;
        pool_result_t      want;
    } pool_row_t;

    // DUT pins; the driven ones are known from time zero
    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_op       = OP_ALLOC;
    logic [ADDR_W-1:0]    i_addr     = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic [ADDR_W-1:0]    o_chunk_addr;
    logic [2:0]           o_status;
    logic [FC_W-1:0]      o_free_count;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_BASE;
    logic [ADDR_W-1:0]    i_cfg_data = '0;

    // pool model; initial values match the state after reset
    logic [31:0]          cfg_base   = '0;
    logic [31:0]          cfg_len    = '0;
    logic [CHUNK_W-1:0]   cfg_chunk  = 21'd64;
    logic [ALIGN_W-1:0]   cfg_lg     = 4'd4;
    logic [31:0]          pool_stack [0:POOL_DEPTH-1];
    int                   free_cnt   = 0;
    logic [63:0]          region_lo  = '0;
    logic [63:0]          region_len = '0;

    pool_result_t         pending_results [$];
    pool_row_t            dir_rows [$];
    int                   fault_count = 0;
    int                   burst_left  = 0;
    int                   rx_hold     = 0;

    fixed_chunk_pool_free_list #(
        .MAX_CHUNKS (POOL_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_addr       (i_addr),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chunk_addr (o_chunk_addr),
        .o_status     (o_status),
        .o_free_count (o_free_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Advance the pool model by one item and return the result it gives
    function automatic pool_result_t pool_step(t_op op, logic [ADDR_W-1:0] addr);
        pool_result_t r;
        logic [63:0]  align;
        logic [63:0]  start;
        logic [63:0]  chunk;
        logic [63:0]  pad;
        logic [63:0]  len;
        logic [63:0]  n;
        int           k;
        r.chunk_addr = '0;
        r.status     = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (free_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    free_cnt--;
                    r.chunk_addr = pool_stack[free_cnt];
                end
            end
            OP_FREE: begin
                if (addr == '0) begin
                    // null pointer: nothing happens
                end else if ({32'd0, addr} < region_lo ||
                             {32'd0, addr} >= region_lo + region_len) begin
                    r.status = ST_BOUNDS;
                end else if (free_cnt >= POOL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pool_stack[free_cnt] = addr;
                    free_cnt++;
                end
            end
            OP_REBUILD: begin
                align = 64'd1 << ((cfg_lg > ALIGN_MAX_LG) ? ALIGN_MAX_LG : cfg_lg);
                start = ({32'd0, cfg_base} + align - 1) & ~(align - 1);
                chunk = ({43'd0, cfg_chunk} + align - 1) & ~(align - 1);
                pad   = start - {32'd0, cfg_base};
                free_cnt   = 0;
                region_len = '0;
                region_lo  = {32'd0, start[31:0]};
                if (start >= ADDR_TOP || pad > {32'd0, cfg_len} || chunk == '0) begin
                    r.status = ST_BADCFG;
                end else begin
                    len = {32'd0, cfg_len} - pad;
                    // keep the region below the top of the address space
                    if (len > ADDR_TOP - start) len = ADDR_TOP - start;
                    if (len <= chunk) begin
                        r.status = ST_BADCFG;
                    end else begin
                        region_len = len;
                        n = len / chunk;
                        if (n > POOL_DEPTH) n = POOL_DEPTH;
                        for (k = 0; k < n; k++) pool_stack[k] = 32'(start + k * chunk);
                        free_cnt = int'(n);
                    end
                end
            end
            default: ;  // undefined op leaves everything alone
        endcase
        r.free_count = free_cnt[FC_W-1:0];
        return r;
    endfunction

    function automatic pool_row_t item_row(t_op op, logic [31:0] addr);
        pool_row_t row;
        row       = '0;
        row.op    = op;
        row.value = addr;
        return row;
    endfunction

    function automatic pool_row_t known_row(t_op op, logic [31:0] addr, logic [31:0] chunk_addr,
                                            t_status st, logic [FC_W-1:0] cnt);
        pool_row_t row;
        row                 = item_row(op, addr);
        row.typed           = 1'b1;
        row.want.chunk_addr = chunk_addr;
        row.want.status     = st;
        row.want.free_count = cnt;
        return row;
    endfunction

    function automatic pool_row_t cfg_row(t_cfg_idx idx, logic [31:0] data);
        pool_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = data;
        return row;
    endfunction

    function automatic void add_cfg_set(logic [31:0] base, logic [31:0] len,
                                        logic [31:0] chunk, logic [31:0] lg);
        dir_rows.push_back(cfg_row(CFG_BASE, base));
        dir_rows.push_back(cfg_row(CFG_BUFLEN, len));
        dir_rows.push_back(cfg_row(CFG_CHUNK, chunk));
        dir_rows.push_back(cfg_row(CFG_ALIGN, lg));
    endfunction

    function automatic void note_fault(string what, logic [31:0] exp_v, logic [31:0] act_v);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_v, act_v);
    endfunction

    // Register write; a run of writes starts only once the pool is idle
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        if (!i_cfg_we) begin
            if (i_valid) i_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BASE:   cfg_base  = data;
            CFG_BUFLEN: cfg_len   = data;
            CFG_CHUNK:  cfg_chunk = data[CHUNK_W-1:0];
            CFG_ALIGN:  cfg_lg    = data[ALIGN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Send one input beat in bursts with random gaps; predict on accept
    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] addr, input logic typed,
                             input pool_result_t want, output pool_result_t got);
        int gap;
        if (i_cfg_we) i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160)
                                                     : $urandom_range(1, 20);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 && i_valid) i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_op    <= op;
        i_addr  <= addr;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        got = pool_step(op, addr);
        pending_results.push_back(typed ? want : got);
    endtask

    // Receiver: short stalls, with an occasional long stretch of full speed
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!i_ready) begin
            i_ready <= 1'b1;
            rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 10);
        end else begin
            i_ready <= 1'b0;
            rx_hold <= $urandom_range(0, 5);
        end
    end

    // Result checker: each beat against the oldest expectation
    always @(posedge i_clk) begin
        pool_result_t want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                note_fault("unexpected result beat, chunk_addr", '0, o_chunk_addr);
            end else begin
                want = pending_results.pop_front();
                if (o_chunk_addr !== want.chunk_addr)
                    note_fault("chunk_addr", want.chunk_addr, o_chunk_addr);
                if (o_status !== want.status)
                    note_fault("status", 32'(want.status), 32'(o_status));
                if (o_free_count !== want.free_count)
                    note_fault("free_count", 32'(want.free_count), 32'(o_free_count));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("fixed_chunk_pool_free_list test failed");
        $finish;
    end

    initial begin
        pool_result_t seen;
        logic [31:0]  owned_chunks [$];
        int           random_sent;
        int           phase_len;
        int           pick;
        int           slot;
        t_op          op_pick;
        logic [31:0]  addr_pick;
        logic [31:0]  base_pick;
        logic [31:0]  len_pick;
        logic [20:0]  chunk_pick;
        logic [3:0]   lg_pick;
        logic [63:0]  align;
        logic [63:0]  span;
        logic [63:0]  pad;
        logic [63:0]  len64;

        // out of reset: empty list, zero-length region
        dir_rows.push_back(known_row(OP_ALLOC, 32'h0, 32'h0, ST_EMPTY, 0));
        dir_rows.push_back(known_row(OP_FREE, 32'h0, 32'h0, ST_OK, 0));
        dir_rows.push_back(known_row(OP_FREE, 32'hFFFF_FFFF, 32'h0, ST_BOUNDS, 0));
        dir_rows.push_back(known_row(OP_NONE, 32'hFFFF_FFFF, 32'h0, ST_OK, 0));
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_BADCFG, 0));
        // zero chunk size
        add_cfg_set(32'h0000_1001, 32'h0000_1000, 32'h0, 32'h0);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_BADCFG, 0));
        // aligned base carries past 32 bits
        add_cfg_set(32'hFFFF_FFF1, 32'hFFFF_FFFF, 32'd16, 32'd4);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_BADCFG, 0));
        // alignment padding longer than the buffer
        add_cfg_set(32'h0000_0011, 32'h0000_0005, 32'd16, 32'd4);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_BADCFG, 0));
        // alignment clamped to 4 KiB, region cut at top of memory, count capped
        add_cfg_set(32'h0000_1000, 32'hFFFF_FFFF, 32'd1, 32'd15);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_OK, 1024));
        dir_rows.push_back(known_row(OP_FREE, 32'h0000_2000, 32'h0, ST_FULL, 1024));
        dir_rows.push_back(item_row(OP_ALLOC, 32'h0));
        dir_rows.push_back(known_row(OP_FREE, 32'h0000_0FFF, 32'h0, ST_BOUNDS, 1023));
        dir_rows.push_back(item_row(OP_FREE, 32'h0000_2001));   // misaligned is not checked
        dir_rows.push_back(item_row(OP_ALLOC, 32'h0));
        dir_rows.push_back(item_row(OP_FREE, 32'hFFFF_FFFF));   // last byte is in range
        dir_rows.push_back(item_row(OP_ALLOC, 32'h0));
        // all-ones layout: region trimmed to one byte
        add_cfg_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h001F_FFFF, 32'h0);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_BADCFG, 0));
        dir_rows.push_back(known_row(OP_ALLOC, 32'h0, 32'h0, ST_EMPTY, 0));
        // length equal to one chunk, then three chunks with a chunk at address 0
        add_cfg_set(32'h0, 32'h0000_0100, 32'h0000_0100, 32'd8);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_BADCFG, 0));
        add_cfg_set(32'h0, 32'h0000_0301, 32'h0000_0100, 32'd8);
        dir_rows.push_back(known_row(OP_REBUILD, 32'h0, 32'h0, ST_OK, 3));
        dir_rows.push_back(item_row(OP_ALLOC, 32'h0));
        dir_rows.push_back(item_row(OP_ALLOC, 32'h0));
        dir_rows.push_back(item_row(OP_ALLOC, 32'h0));
        dir_rows.push_back(known_row(OP_FREE, 32'h0, 32'h0, ST_OK, 0));
        dir_rows.push_back(known_row(OP_ALLOC, 32'h0, 32'h0, ST_EMPTY, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg)
                write_reg(dir_rows[k].reg_idx, dir_rows[k].value);
            else
                send_item(dir_rows[k].op, dir_rows[k].value, dir_rows[k].typed,
                          dir_rows[k].want, seen);
        end

        // random layouts, each followed by a stretch of pool traffic
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            lg_pick = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 8));
            pick = $urandom_range(0, 19);
            if (pick == 0)     chunk_pick = '0;
            else if (pick == 1) chunk_pick = 21'h10_0000;
            else if (pick < 4) chunk_pick = 21'($urandom_range(1, 21'h1F_FFFF));
            else               chunk_pick = 21'($urandom_range(1, 256));
            pick = $urandom_range(0, 9);
            if (pick < 5)      base_pick = $urandom_range(0, 65535);
            else if (pick < 9) base_pick = $urandom;
            else               base_pick = 32'hFFFF_F000 | $urandom_range(0, 4095);

            // size the buffer for a chosen chunk count, mostly small
            align = 64'd1 << ((lg_pick > ALIGN_MAX_LG) ? ALIGN_MAX_LG : lg_pick);
            span  = ({43'd0, chunk_pick} + align - 1) & ~(align - 1);
            pad   = (({32'd0, base_pick} + align - 1) & ~(align - 1)) - {32'd0, base_pick};
            pick  = $urandom_range(0, 19);
            if (pick == 0) begin
                len_pick = $urandom;
            end else if (pick == 1) begin
                len_pick = $urandom_range(0, 64);
            end else begin
                len64 = pad + span * (($urandom_range(0, 7) == 0) ? $urandom_range(1030, 1400)
                                                                  : $urandom_range(2, 40));
                if (span != 0) len64 += {32'd0, $urandom} % span;
                len_pick = (len64 > 64'hFFFF_FFFF) ? '1 : len64[31:0];
            end

            write_reg(CFG_BASE, base_pick);
            write_reg(CFG_BUFLEN, len_pick);
            write_reg(CFG_CHUNK, {11'd0, chunk_pick});
            write_reg(CFG_ALIGN, {28'd0, lg_pick});
            owned_chunks.delete();
            send_item(OP_REBUILD, $urandom, 1'b0, '0, seen);
            random_sent++;

            phase_len = $urandom_range(40, 140);
            repeat (phase_len) begin
                pick      = $urandom_range(0, 99);
                op_pick   = OP_FREE;
                addr_pick = $urandom;
                if (pick < 40) begin
                    op_pick = OP_ALLOC;
                end else if (pick < 72 && owned_chunks.size() != 0) begin
                    // hand back a chunk we hold
                    slot      = $urandom_range(0, owned_chunks.size() - 1);
                    addr_pick = owned_chunks[slot];
                    owned_chunks.delete(slot);
                end else if (pick < 82 && region_len != 0) begin
                    addr_pick = 32'(region_lo + {32'd0, $urandom} % region_len);
                end else if (pick < 86) begin
                    addr_pick = ($urandom_range(0, 1) == 0) ? 32'(region_lo - 1)
                                                            : 32'(region_lo + region_len);
                end else if (pick < 89) begin
                    addr_pick = '0;
                end else if (pick < 93) begin
                    op_pick = OP_REBUILD;
                end else if (pick < 96) begin
                    op_pick = OP_NONE;
                end
                send_item(op_pick, addr_pick, 1'b0, '0, seen);
                random_sent++;
                if (op_pick == OP_ALLOC && seen.status == ST_OK)
                    owned_chunks.push_back(seen.chunk_addr);
                if (op_pick == OP_REBUILD) owned_chunks.delete();
            end
        end

        // drain, then give stray beats a chance to show up
        if (i_valid) i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fault_count == 0)
            $display("fixed_chunk_pool_free_list test passed");
        else
            $display("fixed_chunk_pool_free_list test failed");
        $finish;
    end

endmodule

### fixed_chunk_pool_free_list.f
+incdir+hdl
hdl/fcp_pkg.sv
hdl/fcp_stack_mem.sv
hdl/fcp_rebuild.sv
hdl/fixed_chunk_pool_free_list.sv
verif/tb_top.sv
